/* hdl/utf8ct_pkg.sv */
// utf8ct_pkg: shared types, constants and helpers for the utf-8 cluster
// truncating copy block
// depends on nothing; every module of the block imports it
package utf8ct_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned LenW   = 3;
  localparam int unsigned CpW    = 21;

  // capacity clamp
  localparam int unsigned MaxSize = 4096;
  localparam logic [CfgW-1:0] MaxCap   = CfgW'(MaxSize);
  localparam logic [CfgW-1:0] CfgReset = CfgW'(4096);

  // result queue
  localparam int unsigned QDepth  = 8;
  localparam int unsigned QPtrW   = 3;
  localparam int unsigned QCntW   = 4;
  localparam int unsigned MaxPush = 4;
  localparam int unsigned PushW   = 3;

  // byte classes
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContValue = 8'h80;

  // combining mark ranges
  localparam logic [CpW-1:0] Mark0Lo = 21'h000300;
  localparam logic [CpW-1:0] Mark0Hi = 21'h00036F;
  localparam logic [CpW-1:0] Mark1Lo = 21'h001AB0;
  localparam logic [CpW-1:0] Mark1Hi = 21'h001AFF;
  localparam logic [CpW-1:0] Mark2Lo = 21'h001DC0;
  localparam logic [CpW-1:0] Mark2Hi = 21'h001DFF;
  localparam logic [CpW-1:0] Mark3Lo = 21'h0020D0;
  localparam logic [CpW-1:0] Mark3Hi = 21'h0020FF;
  localparam logic [CpW-1:0] Mark4Lo = 21'h00FE20;
  localparam logic [CpW-1:0] Mark4Hi = 21'h00FE2F;

  // one result item
  typedef struct packed {
    logic            wvalid;
    logic [IdxW-1:0] windex;
    logic [ByteW-1:0] wbyte;
    logic            done;
    logic [IdxW-1:0] len;
  } entry_t;

  // results of one input byte, lanes 0 .. num-1 are live
  typedef struct packed {
    logic [PushW-1:0]          num;
    entry_t [MaxPush-1:0]      ent;
  } push_t;

  function automatic logic is_mark(input logic [CpW-1:0] cp);
    return (cp >= Mark0Lo && cp <= Mark0Hi) ||
           (cp >= Mark1Lo && cp <= Mark1Hi) ||
           (cp >= Mark2Lo && cp <= Mark2Hi) ||
           (cp >= Mark3Lo && cp <= Mark3Hi) ||
           (cp >= Mark4Lo && cp <= Mark4Hi);
  endfunction

  // character length from the lead byte, zero for an invalid lead
  function automatic logic [LenW-1:0] lead_len(input logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    n = '0;
    priority if (!b[7])              n = 3'd1;
    else if (b[7:5] == 3'b110)       n = 3'd2;
    else if (b[7:4] == 4'b1110)      n = 3'd3;
    else if (b[7:3] == 5'b11110)     n = 3'd4;
    else                             n = 3'd0;
    return n;
  endfunction

endpackage

/* hdl/utf8ct_decode.sv */
// utf8ct_decode: input register, character assembly, validation, mark
// detection and fit check; emits up to four results per byte
// depends on utf8ct_pkg
module utf8ct_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [utf8ct_pkg::ByteW-1:0] text_byte_i,
  input  logic [utf8ct_pkg::CfgW-1:0]  cap_i,
  input  logic                        room_i,
  output utf8ct_pkg::push_t           push_o
);
  import utf8ct_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             proc;

  logic             stopped_q, stopped_d;
  logic [IdxW-1:0]  bw_q, bw_d;
  logic [IdxW-1:0]  cs_q, cs_d;
  logic [LenW-1:0]  exp_q, exp_d;
  logic [LenW-1:0]  seen_q, seen_d;
  logic [ByteW-1:0] char_q [3];

  logic             char_we;
  logic [1:0]       pos;
  logic [ByteW-1:0] cur [MaxPush];
  logic [LenW-1:0]  lead;
  logic [LenW-1:0]  n;
  logic [CpW-1:0]   cp;
  logic             mark;
  logic             over;
  logic             finish;

  assign proc       = valid_q && room_i;
  assign in_stall_o = valid_q && !room_i;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= text_byte_i;
    end
  end

  // assembled character with the current byte in place
  assign lead = lead_len(byte_q);
  assign pos  = (seen_q == '0) ? 2'd0 : seen_q[1:0];
  assign n    = (seen_q == '0) ? lead : exp_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur[i] = (pos == 2'(i)) ? byte_q : char_q[i];
    end
    cur[3] = byte_q;
  end

  always_comb begin
    unique case (n)
      3'd1:    cp = {13'b0, cur[0]};
      3'd2:    cp = {10'b0, cur[0][4:0], cur[1][5:0]};
      3'd3:    cp = {5'b0, cur[0][3:0], cur[1][5:0], cur[2][5:0]};
      default: cp = {cur[0][2:0], cur[1][5:0], cur[2][5:0], cur[3][5:0]};
    endcase
  end

  assign mark = (n >= 3'd2) && is_mark(cp);
  assign over = ({2'b0, bw_q} + {11'b0, n} + 14'd1) > {1'b0, cap_i};

  always_comb begin
    stopped_d = stopped_q;
    bw_d      = bw_q;
    cs_d      = cs_q;
    exp_d     = exp_q;
    seen_d    = seen_q;
    char_we   = 1'b0;
    finish    = 1'b0;
    push_o    = '0;
    if (proc) begin
      if (byte_q == '0) begin
        // terminator, then a fresh string
        push_o.num           = 3'd1;
        push_o.ent[0].done   = 1'b1;
        if (cap_i != '0) begin
          push_o.ent[0].wvalid = 1'b1;
          push_o.ent[0].windex = bw_q;
          push_o.ent[0].len    = bw_q;
        end
        stopped_d = 1'b0;
        bw_d      = '0;
        cs_d      = '0;
        exp_d     = '0;
        seen_d    = '0;
      end else if (!stopped_q) begin
        if (seen_q == '0) begin
          if (lead == '0) begin
            stopped_d = 1'b1;
          end else begin
            char_we = 1'b1;
            exp_d   = lead;
            seen_d  = 3'd1;
            finish  = (lead == 3'd1);
          end
        end else begin
          if ((byte_q & ContMask) != ContValue || seen_q > 3'd3) begin
            stopped_d = 1'b1;
            exp_d     = '0;
            seen_d    = '0;
          end else begin
            char_we = (seen_q < 3'd3);
            seen_d  = seen_q + 3'd1;
            finish  = ((seen_q + 3'd1) >= exp_q);
          end
        end
        if (finish) begin
          exp_d  = '0;
          seen_d = '0;
          if (mark && bw_q == '0) begin
            // mark with no base, skipped
          end else if (over) begin
            if (mark) begin
              bw_d = cs_q;
            end
            stopped_d = 1'b1;
          end else begin
            if (!mark) begin
              cs_d = bw_q;
            end
            push_o.num = n;
            for (int i = 0; i < MaxPush; i++) begin
              push_o.ent[i].wvalid = 1'b1;
              push_o.ent[i].windex = bw_q + IdxW'(i);
              push_o.ent[i].wbyte  = cur[i];
            end
            bw_d = bw_q + {9'b0, n};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b0;
      bw_q      <= '0;
      cs_q      <= '0;
      exp_q     <= '0;
      seen_q    <= '0;
    end else begin
      stopped_q <= stopped_d;
      bw_q      <= bw_d;
      cs_q      <= cs_d;
      exp_q     <= exp_d;
      seen_q    <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_q[pos] <= byte_q;
    end
  end

  // results only come from a byte that is being processed
  a_push_needs_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.num != '0) |-> proc)
    else $error("results pushed without a processed byte");

  // a terminator result stands alone
  a_done_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.num != '0 && push_o.ent[0].done) |-> (push_o.num == 3'd1))
    else $error("terminator pushed with other results");

  // the cluster start never runs ahead of the write position
  a_cluster_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_q <= bw_q)
    else $error("cluster start beyond bytes written");

endmodule

/* hdl/utf8ct_queue.sv */
// utf8ct_queue: result queue taking up to four results a cycle and
// delivering one a cycle on the output channel while it is not stalled
// depends on utf8ct_pkg
module utf8ct_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  utf8ct_pkg::push_t    push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output utf8ct_pkg::entry_t   head_o
);
  import utf8ct_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_q];
  assign room_o      = (cnt_q <= QCntW'(QDepth - MaxPush));
  assign cnt_d       = cnt_q + {1'b0, push_i.num} - {3'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.num;
      rd_q  <= rd_q + {2'b0, pop};
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxPush; i++) begin
      if (PushW'(i) < push_i.num) begin
        mem_q[wr_q + QPtrW'(i)] <= push_i.ent[i];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != '0) |-> room_o)
    else $error("push into queue without room");

endmodule

/* hdl/utf8_cluster_truncating_copy.sv */
// utf8_cluster_truncating_copy: top level of the utf-8 cluster truncating copy
// depends on utf8ct_pkg, utf8ct_decode, utf8ct_queue
//
// usage
//   input channel: one source byte per transfer on text_byte_i
//     (in_valid_i / in_stall_o); a zero byte ends the string
//   output channel: one result per transfer (out_valid_o / out_stall_i),
//     a destination write or the terminator write with done_res_o and
//     copied_length_o; each character gives one write per byte
//   buffer_size_we_i / buffer_size_i write the destination capacity,
//     only while the block is idle; values above 4096 act as 4096
//   path: a byte accepted into the input register is decoded there and its
//     results are written into the result queue, which offers them on the
//     output channel; the input register holds the byte while the queue
//     lacks room
//   throughput: one byte per cycle unless stalled; the eight-entry queue
//     takes up to four results a cycle, drains one a cycle unless the
//     receiver stalls; input stalls only while more than four are queued
//   reset: string state cleared, capacity back to 4096, queue empty
//   receiver stall: results wait in the queue, input keeps flowing until
//     the queue lacks room for a whole character
module utf8_cluster_truncating_copy (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         buffer_size_we_i,
  input  logic [utf8ct_pkg::CfgW-1:0]  buffer_size_i,
  // source bytes
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [utf8ct_pkg::ByteW-1:0] text_byte_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         write_valid_o,
  output logic [utf8ct_pkg::IdxW-1:0]  write_index_o,
  output logic [utf8ct_pkg::ByteW-1:0] write_byte_o,
  output logic                         done_res_o,
  output logic [utf8ct_pkg::IdxW-1:0]  copied_length_o
);
  import utf8ct_pkg::*;

  logic [CfgW-1:0] size_q;
  logic [CfgW-1:0] cap;
  push_t           push;
  logic            room;
  entry_t          head;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CfgReset;
    end else if (buffer_size_we_i) begin
      size_q <= buffer_size_i;
    end
  end

  // clamp to the largest destination
  assign cap = (size_q > MaxCap) ? MaxCap : size_q;

  // decode and fit check
  utf8ct_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .cap_i       (cap),
    .room_i      (room),
    .push_o      (push)
  );

  // result queue and output channel
  utf8ct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign write_valid_o   = head.wvalid;
  assign write_index_o   = head.windex;
  assign write_byte_o    = head.wbyte;
  assign done_res_o      = head.done;
  assign copied_length_o = head.len;

  // a terminator result carries its length as its write position
  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o && write_valid_o) |-> (copied_length_o == write_index_o))
    else $error("terminator length differs from its position");

  // ordinary writes carry no length
  a_write_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (write_valid_o && copied_length_o == '0))
    else $error("data write with length or without write");

  // the clamped capacity never exceeds the largest destination
  a_cap_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap <= MaxCap)
    else $error("capacity above the largest destination");

endmodule

/* tb/utf8_cluster_truncating_copy_test.sv */
// utf8_cluster_truncating_copy_test: self-checking bench for the utf-8 cluster truncating copy
// a queue-fed driver, a bit-accurate copy predictor and a checking monitor
// depends on utf8ct_pkg and utf8_cluster_truncating_copy
module utf8_cluster_truncating_copy_test;

  import utf8ct_pkg::*;

  // run control
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned IdlePct      = 9;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned RandomBytes  = 255;

  // what the driver does with the head of its queue
  typedef enum logic [1:0] {
    SRC_BYTE,   // offer one source byte
    SRC_SIZE,   // write the capacity register once the block is quiet
    SRC_PAUSE   // hold off until every result is back
  } src_kind_e;

  typedef struct {
    src_kind_e       kind;
    logic [CfgW-1:0] value;
  } src_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // block inputs, known from time zero
  logic             in_valid  = 1'b0;
  logic [ByteW-1:0] text_byte = '0;
  logic             out_stall = 1'b0;
  logic             size_we   = 1'b0;
  logic [CfgW-1:0]  size_data = CfgReset;

  // block outputs
  logic             in_stall;
  logic             out_valid;
  logic             w_valid;
  logic [IdxW-1:0]  w_index;
  logic [ByteW-1:0] w_byte;
  logic             w_done;
  logic [IdxW-1:0]  w_len;

  utf8_cluster_truncating_copy uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .buffer_size_we_i (size_we),
    .buffer_size_i    (size_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .text_byte_i      (text_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .write_valid_o    (w_valid),
    .write_index_o    (w_index),
    .write_byte_o     (w_byte),
    .done_res_o       (w_done),
    .copied_length_o  (w_len)
  );

  src_item_t source_items[$];   // pending stimulus, head is on offer
  entry_t    awaited_writes[$]; // predicted results, oldest first

  int unsigned error_count  = 0;
  int unsigned sent_count   = 0;
  int unsigned recv_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned queued_bytes = 0;
  int unsigned string_count = 0;
  int unsigned size_writes  = 0;

  // predictor state, a private copy of the block's string state
  logic [CfgW-1:0]  m_size    = CfgReset;
  logic             m_stopped = 1'b0;
  logic [IdxW-1:0]  m_written = '0;
  logic [IdxW-1:0]  m_cluster = '0;
  logic [ByteW-1:0] m_chr [4];
  logic [LenW-1:0]  m_need    = '0;
  logic [LenW-1:0]  m_seen    = '0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic logic mark_codepoint(input int unsigned cp);
    return (cp >= 'h0300 && cp <= 'h036F) || (cp >= 'h1AB0 && cp <= 'h1AFF) ||
           (cp >= 'h1DC0 && cp <= 'h1DFF) || (cp >= 'h20D0 && cp <= 'h20FF) ||
           (cp >= 'hFE20 && cp <= 'hFE2F);
  endfunction

  // usable room, register values past the maximum clamp down
  function automatic int unsigned room_now();
    return (m_size > MaxCap) ? MaxSize : int'(m_size);
  endfunction

  // a whole character is assembled: decode, place or truncate
  function automatic void place_char();
    int unsigned n;
    int unsigned cp;
    int          i;
    logic        mark;
    entry_t      e;
    n = m_need;
    case (n)
      1:       cp = m_chr[0];
      2:       cp = m_chr[0] & 'h1F;
      3:       cp = m_chr[0] & 'h0F;
      default: cp = m_chr[0] & 'h07;
    endcase
    for (i = 1; i < n; i++) cp = (cp << 6) | (m_chr[i] & 'h3F);
    m_need = '0;
    m_seen = '0;
    mark = (n >= 2) && mark_codepoint(cp);
    // a mark with no base is dropped
    if (mark && m_written == 0) return;
    // no room for the character plus terminator
    if (m_written + n + 1 > room_now()) begin
      if (mark) m_written = m_cluster;
      m_stopped = 1'b1;
      return;
    end
    if (!mark) m_cluster = m_written;
    for (i = 0; i < n; i++) begin
      e        = '0;
      e.wvalid = 1'b1;
      e.windex = m_written;
      e.wbyte  = m_chr[i];
      awaited_writes.push_back(e);
      m_written++;
    end
  endfunction

  function automatic void predict_copy(input logic [ByteW-1:0] b);
    entry_t      e;
    int unsigned n;
    if (b == 0) begin
      // terminator ends the string and clears its state
      e      = '0;
      e.done = 1'b1;
      if (room_now() > 0) begin
        e.wvalid = 1'b1;
        e.windex = m_written;
        e.len    = m_written;
      end
      awaited_writes.push_back(e);
      m_stopped = 1'b0;
      m_written = '0;
      m_cluster = '0;
      m_need    = '0;
      m_seen    = '0;
      return;
    end
    if (m_stopped) return;
    if (m_seen == 0) begin
      casez (b)
        8'b0???????: n = 1;
        8'b110?????: n = 2;
        8'b1110????: n = 3;
        8'b11110???: n = 4;
        default:     n = 0;
      endcase
      // stray continuation or 11111xxx lead
      if (n == 0) begin
        m_stopped = 1'b1;
        return;
      end
      m_chr[0] = b;
      m_need   = LenW'(n);
      m_seen   = 3'd1;
    end else begin
      // broken continuation drops the partial character
      if (b[7:6] != 2'b10 || m_seen > 3) begin
        m_stopped = 1'b1;
        m_need    = '0;
        m_seen    = '0;
        return;
      end
      m_chr[m_seen[1:0]] = b;
      m_seen++;
    end
    if (m_seen >= m_need) place_char();
  endfunction

  // ---------------------------------------------------------------------
  // driver: offers source bytes, applies size writes and pauses
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : source_drive
    src_item_t        head;
    logic             nxt_valid;
    logic [ByteW-1:0] nxt_byte;
    logic             nxt_we;
    int unsigned      quiet_cycles;
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      size_we      <= 1'b0;
      quiet_cycles = 0;
      m_size       = CfgReset;
      m_stopped    = 1'b0;
      m_written    = '0;
      m_cluster    = '0;
      m_need       = '0;
      m_seen       = '0;
    end else begin
      nxt_valid = in_valid;
      nxt_byte  = text_byte;
      nxt_we    = 1'b0;
      // byte transfer at this edge
      if (in_valid && !in_stall) begin
        predict_copy(text_byte);
        source_items.delete(0);
        sent_count++;
        nxt_valid = 1'b0;
      end
      // a stalled byte stays on offer untouched
      if (!nxt_valid && source_items.size() > 0) begin
        head = source_items[0];
        if (head.kind == SRC_BYTE) begin
          // random gaps, except for one long unbroken stretch
          if ((sent_count >= 150 && sent_count < 230) ||
              $urandom_range(0, 99) >= IdlePct) begin
            nxt_valid = 1'b1;
            nxt_byte  = head.value[ByteW-1:0];
          end
        end else begin
          // wait out results and any byte still in flight with none
          if (awaited_writes.size() == 0) quiet_cycles++;
          else quiet_cycles = 0;
          if (quiet_cycles >= SettleCycles) begin
            quiet_cycles = 0;
            if (head.kind == SRC_SIZE) begin
              nxt_we    = 1'b1;
              size_data <= head.value;
              m_size    = head.value;
              size_writes++;
            end
            source_items.delete(0);
          end
        end
      end
      in_valid  <= nxt_valid;
      text_byte <= nxt_byte;
      size_we   <= nxt_we;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: random stalls, one long hold-off, field checks
  // ---------------------------------------------------------------------

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : result_check
    entry_t      want;
    logic        nxt_stall;
    int unsigned hold_left;
    logic        hold_done;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        recv_count++;
        if (awaited_writes.size() == 0) begin
          error_count++;
          $display("%0t: expected no result, actual index %0d byte %0d done %0d",
                   $time, w_index, w_byte, w_done);
        end else begin
          want = awaited_writes.pop_front();
          compare_field("write_valid", want.wvalid, w_valid);
          compare_field("write_index", want.windex, w_index);
          compare_field("write_byte", want.wbyte, w_byte);
          compare_field("done_res", want.done, w_done);
          compare_field("copied_length", want.len, w_len);
        end
      end
      // long hold-off while the sender keeps offering, fills the block
      if (!hold_done && recv_count >= 100 && in_valid) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (recv_count >= 170 && recv_count < 250) begin
        nxt_stall = 1'b0;
      end else begin
        nxt_stall = ($urandom_range(0, 99) < IdlePct);
      end
      out_stall <= nxt_stall;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  task automatic push_byte(input logic [ByteW-1:0] b);
    source_items.push_back('{SRC_BYTE, CfgW'(b)});
    queued_bytes++;
    if (b == 0) string_count++;
  endtask

  task automatic push_size(input logic [CfgW-1:0] v);
    source_items.push_back('{SRC_SIZE, v});
  endtask

  task automatic push_bytes(input logic [ByteW-1:0] bs[$]);
    foreach (bs[i]) push_byte(bs[i]);
  endtask

  // utf-8 encoding of one codepoint
  task automatic push_codepoint(input int unsigned cp);
    if (cp < 'h80) begin
      push_byte(cp[7:0]);
    end else if (cp < 'h800) begin
      push_byte(8'hC0 | cp[10:6]);
      push_byte(8'h80 | cp[5:0]);
    end else if (cp < 'h10000) begin
      push_byte(8'hE0 | cp[15:12]);
      push_byte(8'h80 | cp[11:6]);
      push_byte(8'h80 | cp[5:0]);
    end else begin
      push_byte(8'hF0 | cp[20:18]);
      push_byte(8'h80 | cp[17:12]);
      push_byte(8'h80 | cp[11:6]);
      push_byte(8'h80 | cp[5:0]);
    end
  endtask

  // mostly well-formed text with marks, some noise and broken characters
  task automatic push_random_string();
    int unsigned nchars;
    int unsigned r;
    int unsigned c;
    nchars = $urandom_range(0, 12);
    for (c = 0; c < nchars; c++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        push_codepoint($urandom_range(1, 'h7F));
      end else if (r < 48) begin
        push_codepoint($urandom_range('h80, 'h7FF));
      end else if (r < 60) begin
        push_codepoint($urandom_range('h800, 'hFFFF));
      end else if (r < 68) begin
        push_codepoint($urandom_range('h10000, 'h10FFFF));
      end else if (r < 88) begin
        // combining mark from one of the five blocks
        case ($urandom_range(0, 4))
          0:       push_codepoint($urandom_range('h0300, 'h036F));
          1:       push_codepoint($urandom_range('h1AB0, 'h1AFF));
          2:       push_codepoint($urandom_range('h1DC0, 'h1DFF));
          3:       push_codepoint($urandom_range('h20D0, 'h20FF));
          default: push_codepoint($urandom_range('hFE20, 'hFE2F));
        endcase
      end else if (r < 93) begin
        push_byte(8'($urandom_range(1, 255)));
      end else if (r < 97) begin
        // lead then a byte that is not a continuation
        push_byte(8'($urandom_range('hC0, 'hF7)));
        push_byte(8'($urandom_range(1, 'h7F)));
      end else begin
        // string ends inside a character
        push_byte(8'($urandom_range('hC0, 'hF7)));
        break;
      end
    end
    push_byte(8'h00);
  endtask

  initial begin : stimulus
    int unsigned     random_start;
    int unsigned     phase_start;
    logic [CfgW-1:0] size_pick;

    // leading mark skipped, all four lengths, mark after a base
    push_bytes('{8'hCC, 8'h80, 8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hCC, 8'h81, 8'h00});
    // out-of-range four-byte lead, then a broken continuation
    push_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC3, 8'h41, 8'h00});
    // stray continuation as lead
    push_bytes('{8'h80, 8'h00});
    // zero inside a character
    push_bytes('{8'hE2, 8'h82, 8'h00});
    // zero capacity, terminator without a write
    push_size('0);
    push_byte(8'h00);
    // mark that does not fit rolls back to its base
    push_size(13'd4);
    push_bytes('{8'h41, 8'h42, 8'hCC, 8'h81, 8'h00});
    // register maximum clamps to the largest size
    push_size('1);
    push_bytes('{8'h7F, 8'hFF, 8'h00});

    // random phases, one capacity each
    random_start = queued_bytes;
    while (queued_bytes - random_start < RandomBytes) begin
      case ($urandom_range(0, 4))
        0, 1:    size_pick = CfgW'($urandom_range(0, 24));
        2:       size_pick = MaxCap;
        3:       size_pick = '1;
        default: size_pick = CfgW'($urandom_range(0, 8191));
      endcase
      push_size(size_pick);
      phase_start = queued_bytes;
      while (queued_bytes - phase_start < 35) begin
        push_random_string();
        // pause mid-phase until the block has drained
        if (queued_bytes - phase_start >= 15 && queued_bytes - phase_start < 30 &&
            $urandom_range(0, 3) == 0)
          source_items.push_back('{SRC_PAUSE, '0});
      end
    end
    push_size(MaxCap);
    push_bytes('{8'h01, 8'h00});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain, then leave room for anything late
    while (source_items.size() > 0 || awaited_writes.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d source bytes in %0d strings under %0d capacity writes",
             sent_count, string_count, size_writes);
    $display("checked %0d results across random stalls and one long hold-off", recv_count);
    if (error_count == 0 && awaited_writes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
